/* rtl/core/lsfd_pkg.sv */
// shared types and constants of the learning switch forwarding decision
`default_nettype none
package lsfd_pkg;

  localparam int PORT_W = 3;
  localparam int NODE_W = 8;
  localparam int ACT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_DROP    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/lsfd_if.sv */
// header request and decision channels
`default_nettype none
interface lsfd_hdr_if;
  logic                        valid;
  logic                        ready;
  logic [lsfd_pkg::PORT_W-1:0] ingress_port;
  logic [lsfd_pkg::NODE_W-1:0] source_node;
  logic [lsfd_pkg::NODE_W-1:0] dest_node;

  modport source(output valid, ingress_port, source_node, dest_node, input ready);
  modport sink(input valid, ingress_port, source_node, dest_node, output ready);
endinterface

interface lsfd_dec_if;
  logic                        valid;
  logic                        ready;
  logic [lsfd_pkg::ACT_W-1:0]  action;
  logic [lsfd_pkg::PORT_W-1:0] egress_port;

  modport source(output valid, action, egress_port, input ready);
  modport sink(input valid, action, egress_port, output ready);
endinterface
`default_nettype wire

/* rtl/core/learning_switch_forward_decision.sv */
// learning switch forwarding decision: a request is registered in idle, the table is read
// with one table read per cycle over all entries, the source is written back, the decision registered
// a dropped request skips scan and write back; the next request is taken once the decision is registered
// a finished decision waits in the output register while the next request is taken
// reset clears all entry valid bits and own node id, no clearing pass
`default_nettype none
module learning_switch_forward_decision #(
  parameter int NUM_PORTS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [lsfd_pkg::NODE_W-1:0] cfg_wdata,
  lsfd_hdr_if.sink                         in_hdr,
  lsfd_dec_if.source                       out_dec
);

  localparam int AW = $clog2(NUM_PORTS);

  lsfd_pkg::tbl_ctl_t tbl_ctl;
  logic [AW-1:0]      tbl_rd_addr;
  logic [AW-1:0]      tbl_wr_addr;
  lsfd_pkg::entry_t   tbl_wr_data;
  lsfd_pkg::entry_t   tbl_rd_data;

  lsfd_ctrl #(
    .DEPTH(NUM_PORTS),
    .AW   (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_hdr     (in_hdr),
    .out_dec    (out_dec),
    .tbl_ctl    (tbl_ctl),
    .tbl_rd_addr(tbl_rd_addr),
    .tbl_wr_addr(tbl_wr_addr),
    .tbl_wr_data(tbl_wr_data),
    .tbl_rd_data(tbl_rd_data)
  );

  lsfd_table #(
    .DEPTH(NUM_PORTS),
    .AW   (AW)
  ) u_table (
    .clk    (clk),
    .ctl    (tbl_ctl),
    .rd_addr(tbl_rd_addr),
    .wr_addr(tbl_wr_addr),
    .wr_data(tbl_wr_data),
    .rd_data(tbl_rd_data)
  );

endmodule
`default_nettype wire

/* rtl/core/lsfd_table.sv */
// forwarding table memory, one write and one registered read port
`default_nettype none
module lsfd_table #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic               clk,
  input  wire lsfd_pkg::tbl_ctl_t ctl,
  input  wire logic [AW-1:0]      rd_addr,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire lsfd_pkg::entry_t   wr_data,
  output lsfd_pkg::entry_t        rd_data
);

  lsfd_pkg::entry_t mem [DEPTH];
  lsfd_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* rtl/core/lsfd_ctrl.sv */
// sequencer: drop check, table scan for learn and lookup, write back, decision register
`default_nettype none
module lsfd_ctrl #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [lsfd_pkg::NODE_W-1:0] cfg_wdata,
  lsfd_hdr_if.sink                         in_hdr,
  lsfd_dec_if.source                       out_dec,
  output lsfd_pkg::tbl_ctl_t               tbl_ctl,
  output logic [AW-1:0]                    tbl_rd_addr,
  output logic [AW-1:0]                    tbl_wr_addr,
  output lsfd_pkg::entry_t                 tbl_wr_data,
  input  wire lsfd_pkg::entry_t            tbl_rd_data
);

  localparam logic [AW:0]   CNT_END  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  lsfd_pkg::state_t            state_r, state_nxt;
  logic [lsfd_pkg::NODE_W-1:0] own_r, own_nxt;
  logic [DEPTH-1:0]            valid_r, valid_nxt;
  logic [lsfd_pkg::PORT_W-1:0] port_r, port_nxt;
  logic [lsfd_pkg::NODE_W-1:0] src_r, src_nxt;
  logic [lsfd_pkg::NODE_W-1:0] dst_r, dst_nxt;
  logic                        drop_r, drop_nxt;
  logic [AW:0]                 rd_cnt_r, rd_cnt_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]               cmp_idx_r, cmp_idx_nxt;
  logic                        src_hit_r, src_hit_nxt;
  logic [AW-1:0]               src_idx_r, src_idx_nxt;
  logic                        free_hit_r, free_hit_nxt;
  logic [AW-1:0]               free_idx_r, free_idx_nxt;
  logic                        dst_hit_r, dst_hit_nxt;
  logic [lsfd_pkg::PORT_W-1:0] dst_port_r, dst_port_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [lsfd_pkg::ACT_W-1:0]  out_act_r, out_act_nxt;
  logic [lsfd_pkg::PORT_W-1:0] out_port_r, out_port_nxt;
  logic                        ent_vld;

  always_comb begin
    state_nxt    = state_r;
    own_nxt      = cfg_we ? cfg_wdata : own_r;
    valid_nxt    = valid_r;
    port_nxt     = port_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    drop_nxt     = drop_r;
    rd_cnt_nxt   = rd_cnt_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    src_hit_nxt  = src_hit_r;
    src_idx_nxt  = src_idx_r;
    free_hit_nxt = free_hit_r;
    free_idx_nxt = free_idx_r;
    dst_hit_nxt  = dst_hit_r;
    dst_port_nxt = dst_port_r;
    out_vld_nxt  = out_vld_r && !out_dec.ready;
    out_act_nxt  = out_act_r;
    out_port_nxt = out_port_r;
    in_hdr.ready = 1'b0;
    tbl_ctl      = '{rd_en: 1'b0, wr_en: 1'b0};
    tbl_rd_addr  = rd_cnt_r[AW-1:0];
    tbl_wr_addr  = src_hit_r ? src_idx_r : free_idx_r;
    tbl_wr_data  = '{node: src_r, port: port_r};
    ent_vld      = valid_r[cmp_idx_r];

    case (state_r)
      lsfd_pkg::ST_IDLE: begin
        // no request is taken while reset is held
        in_hdr.ready = rst_n;
        if (in_hdr.valid) begin
          port_nxt     = in_hdr.ingress_port;
          src_nxt      = in_hdr.source_node;
          dst_nxt      = in_hdr.dest_node;
          drop_nxt     = (in_hdr.dest_node == own_r) ||
                         (in_hdr.dest_node == in_hdr.source_node);
          rd_cnt_nxt   = '0;
          src_hit_nxt  = 1'b0;
          free_hit_nxt = 1'b0;
          dst_hit_nxt  = 1'b0;
          state_nxt    = drop_nxt ? lsfd_pkg::ST_RESULT : lsfd_pkg::ST_SCAN;
        end
      end

      lsfd_pkg::ST_SCAN: begin
        // issue one read per cycle, compare the entry read the cycle before
        if (rd_cnt_r != CNT_END) begin
          tbl_ctl.rd_en = 1'b1;
          rd_cnt_nxt    = rd_cnt_r + 1'b1;
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = rd_cnt_r[AW-1:0];
        end
        if (cmp_vld_r) begin
          if (ent_vld && tbl_rd_data.node == src_r && !src_hit_r) begin
            src_hit_nxt = 1'b1;
            src_idx_nxt = cmp_idx_r;
          end
          if (!ent_vld && !free_hit_r) begin
            free_hit_nxt = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          // src never equals dst here, so learning cannot change the lookup
          if (ent_vld && tbl_rd_data.node == dst_r && !dst_hit_r) begin
            dst_hit_nxt  = 1'b1;
            dst_port_nxt = tbl_rd_data.port;
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = lsfd_pkg::ST_WRITE;
          end
        end
      end

      lsfd_pkg::ST_WRITE: begin
        // refresh a known source, else fill the first free entry if there is one
        if (src_hit_r || free_hit_r) begin
          tbl_ctl.wr_en = 1'b1;
        end
        if (!src_hit_r && free_hit_r) begin
          valid_nxt[free_idx_r] = 1'b1;
        end
        state_nxt = lsfd_pkg::ST_RESULT;
      end

      lsfd_pkg::ST_RESULT: begin
        if (!out_vld_r || out_dec.ready) begin
          out_vld_nxt = 1'b1;
          if (drop_r) begin
            out_act_nxt  = lsfd_pkg::ACT_DROP;
            out_port_nxt = '0;
          end else if (dst_hit_r) begin
            out_act_nxt  = lsfd_pkg::ACT_FORWARD;
            out_port_nxt = dst_port_r;
          end else begin
            out_act_nxt  = lsfd_pkg::ACT_FLOOD;
            out_port_nxt = '0;
          end
          state_nxt = lsfd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lsfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lsfd_pkg::ST_IDLE;
      own_r     <= '0;
      valid_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      own_r     <= own_nxt;
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    port_r     <= port_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    drop_r     <= drop_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    src_hit_r  <= src_hit_nxt;
    src_idx_r  <= src_idx_nxt;
    free_hit_r <= free_hit_nxt;
    free_idx_r <= free_idx_nxt;
    dst_hit_r  <= dst_hit_nxt;
    dst_port_r <= dst_port_nxt;
    out_act_r  <= out_act_nxt;
    out_port_r <= out_port_nxt;
  end

  assign out_dec.valid       = out_vld_r;
  assign out_dec.action      = out_act_r;
  assign out_dec.egress_port = out_port_r;

endmodule
`default_nettype wire

/* tb/sv/lsfd_decision_check.sv */
// predicts and compares the forwarding decisions of the learning switch
module lsfd_decision_check #(
  parameter int NUM_PORTS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lsfd_pkg::NODE_W-1:0] cfg_wdata,
  lsfd_hdr_if                         hdr,
  lsfd_dec_if                         dec,
  output int                          mismatches,
  output int                          pending
);

  typedef struct packed {
    logic [lsfd_pkg::ACT_W-1:0]  action;
    logic [lsfd_pkg::PORT_W-1:0] egress_port;
  } decision_t;

  logic [lsfd_pkg::NODE_W-1:0] own_id;
  logic                        tbl_valid [NUM_PORTS];
  logic [lsfd_pkg::NODE_W-1:0] tbl_node  [NUM_PORTS];
  logic [lsfd_pkg::PORT_W-1:0] tbl_port  [NUM_PORTS];
  decision_t                   decisions_due [$];
  int                          err_count = 0;

  // learn the source, then look up the destination
  function automatic decision_t route_and_learn(input logic [lsfd_pkg::PORT_W-1:0] port,
                                                input logic [lsfd_pkg::NODE_W-1:0] src,
                                                input logic [lsfd_pkg::NODE_W-1:0] dst);
    decision_t d;
    int        free_idx;
    bit        seen;
    d.action = lsfd_pkg::ACT_DROP;
    d.egress_port = '0;
    free_idx = -1;
    seen = 1'b0;
    if (dst == own_id || dst == src) return d;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (tbl_valid[i]) begin
        if (!seen && tbl_node[i] == src) begin
          tbl_port[i] = port;
          seen = 1'b1;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    // nothing learned while the table is full
    if (!seen && free_idx >= 0) begin
      tbl_valid[free_idx] = 1'b1;
      tbl_node[free_idx] = src;
      tbl_port[free_idx] = port;
    end
    d.action = lsfd_pkg::ACT_FLOOD;
    // scan downward so the lowest matching entry wins
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_node[i] == dst) begin
        d.action = lsfd_pkg::ACT_FORWARD;
        d.egress_port = tbl_port[i];
      end
    end
    return d;
  endfunction

  always @(posedge clk) begin : watch
    decision_t want;
    if (!rst_n) begin
      own_id = '0;
      for (int i = 0; i < NUM_PORTS; i++) tbl_valid[i] = 1'b0;
      decisions_due.delete();
    end else begin
      if (dec.valid && dec.ready) begin
        if (decisions_due.size() == 0) begin
          err_count++;
          $error("decision with no request waiting: action %0d egress_port %0d",
                 dec.action, dec.egress_port);
        end else begin
          want = decisions_due.pop_front();
          if (dec.action !== want.action) begin
            err_count++;
            $error("action: expected %0d, got %0d", want.action, dec.action);
          end
          if (dec.egress_port !== want.egress_port) begin
            err_count++;
            $error("egress_port: expected %0d, got %0d", want.egress_port,
                   dec.egress_port);
          end
        end
      end
      if (cfg_we) own_id = cfg_wdata;
      if (hdr.valid && hdr.ready) begin
        decisions_due.push_back(route_and_learn(hdr.ingress_port, hdr.source_node,
                                                hdr.dest_node));
      end
    end
    mismatches <= err_count;
    pending <= int'(decisions_due.size());
  end

endmodule

/* tb/sv/learning_switch_forward_decision_test.sv */
// stimulus and verdict for the learning switch forwarding decision
module learning_switch_forward_decision_test;

  localparam int NUM_PORTS   = 8;
  localparam int LATENCY     = NUM_PORTS + 4;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 450;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [lsfd_pkg::NODE_W-1:0] cfg_wdata;
  int                          mismatches;
  int                          pending;

  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  bit                          hold_req = 1'b0;
  logic [lsfd_pkg::NODE_W-1:0] own_id_now = '0;
  logic [lsfd_pkg::NODE_W-1:0] known_nodes [8] = '{8'h01, 8'hFE, 8'h80, 8'h7F,
                                                   8'h55, 8'hAA, 8'h00, 8'hFF};

  lsfd_hdr_if hdr_ch();
  lsfd_dec_if dec_ch();

  learning_switch_forward_decision #(.NUM_PORTS(NUM_PORTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_hdr   (hdr_ch),
    .out_dec  (dec_ch)
  );

  lsfd_decision_check #(.NUM_PORTS(NUM_PORTS)) decision_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .hdr       (hdr_ch),
    .dec       (dec_ch),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // decision receiver with random stalls and one long hold-off
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    dec_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        dec_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
        dec_ch.ready <= 1'b0;
      end else begin
        dec_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_header(input logic [lsfd_pkg::PORT_W-1:0] port,
                             input logic [lsfd_pkg::NODE_W-1:0] src,
                             input logic [lsfd_pkg::NODE_W-1:0] dst);
    while ($urandom_range(99) < send_idle_pct) begin
      hdr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    hdr_ch.valid <= 1'b1;
    hdr_ch.ingress_port <= port;
    hdr_ch.source_node <= src;
    hdr_ch.dest_node <= dst;
    do @(posedge clk); while (!hdr_ch.ready);
  endtask

  // stop offering requests and wait until every decision is back
  task automatic drain();
    hdr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_own_id(input logic [lsfd_pkg::NODE_W-1:0] id);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
    own_id_now = id;
  endtask

  // mostly learned nodes, with drops, misses and unknown sources mixed in
  task automatic send_random();
    logic [lsfd_pkg::PORT_W-1:0] port;
    logic [lsfd_pkg::NODE_W-1:0] src;
    logic [lsfd_pkg::NODE_W-1:0] dst;
    int                          pick;
    port = lsfd_pkg::PORT_W'($urandom_range(7));
    src = known_nodes[$urandom_range(7)];
    dst = known_nodes[$urandom_range(7)];
    pick = $urandom_range(99);
    if (pick < 10) dst = lsfd_pkg::NODE_W'($urandom_range(255));
    else if (pick < 18) dst = own_id_now;
    else if (pick < 25) dst = src;
    else if (pick < 32) src = lsfd_pkg::NODE_W'($urandom_range(255));
    send_header(port, src, dst);
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hdr_ch.valid = 1'b0;
    hdr_ch.ingress_port = '0;
    hdr_ch.source_node = '0;
    hdr_ch.dest_node = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // own id is zero out of reset
    send_header(3'd0, 8'h01, 8'h00);
    send_header(3'd7, 8'h01, 8'h01);
    send_header(3'd3, 8'h01, 8'hFE);
    send_header(3'd5, 8'hFE, 8'h01);
    send_header(3'd6, 8'h01, 8'hFE);
    send_header(3'd2, 8'hFE, 8'h01);
    send_header(3'd7, 8'hFF, 8'h00);
    send_header(3'd1, 8'h80, 8'h7F);
    send_header(3'd4, 8'h7F, 8'h80);
    send_header(3'd0, 8'h55, 8'hAA);
    send_header(3'd7, 8'hAA, 8'h55);
    send_header(3'd2, 8'h00, 8'hFF);
    send_header(3'd6, 8'hFF, 8'h55);
    // table is full from here on
    send_header(3'd3, 8'h33, 8'h01);
    send_header(3'd5, 8'h44, 8'h33);
    send_header(3'd1, 8'h00, 8'hFF);
    send_header(3'd7, 8'h80, 8'h80);

    set_own_id(8'hFF);
    send_idle_pct = 37;
    recv_idle_pct = 61;
    for (int n = 0; n < PHASE_ITEMS; n++) send_random();

    set_own_id(known_nodes[$urandom_range(7)]);
    send_idle_pct = 61;
    recv_idle_pct = 37;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) drain();
      send_random();
    end

    set_own_id(8'h00);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      send_random();
    end

    set_own_id(lsfd_pkg::NODE_W'($urandom_range(255)));
    for (int n = 0; n < PHASE_ITEMS; n++) send_random();

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* learning_switch_forward_decision.f */
rtl/core/lsfd_pkg.sv
rtl/core/lsfd_if.sv
rtl/core/lsfd_table.sv
rtl/core/lsfd_ctrl.sv
rtl/core/learning_switch_forward_decision.sv
tb/sv/lsfd_decision_check.sv
tb/sv/learning_switch_forward_decision_test.sv
